// ----- sv/bale_pkg.sv -----
// Shared constants, types and helpers of the bounded array list engine.
`timescale 1ns / 1ps

package bale_pkg;

  localparam int CAPACITY   = 8;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W      = $clog2(CAPACITY + 1);

  localparam int ACTION_W = 4;
  localparam int POS_W    = 4;
  localparam int VALUE_W  = 32;
  localparam int LEN_W    = 4;
  localparam int CMP_W    = (POS_W > CNT_W) ? POS_W : CNT_W;

  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = 1;
  localparam int QCNT_W  = 2;

  localparam logic [ACTION_W-1:0] ACT_LAST = 4'd11;

  typedef logic [DATA_WIDTH-1:0] word_t;

  typedef enum logic [3:0] {
    OP_PUSH_BACK     = 4'd0,
    OP_PUSH_FRONT    = 4'd1,
    OP_POP_BACK      = 4'd2,
    OP_POP_FRONT     = 4'd3,
    OP_INSERT_AT     = 4'd4,
    OP_INSERT_SORTED = 4'd5,
    OP_ERASE_AT      = 4'd6,
    OP_ERASE_VALUE   = 4'd7,
    OP_FIND          = 4'd8,
    OP_SORT          = 4'd9,
    OP_CLEAR         = 4'd10,
    OP_READ_AT       = 4'd11,
    OP_NONE          = 4'd12
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [POS_W-1:0] position;
    word_t            value;
  } cmd_t;

  typedef enum logic {
    BS_IDLE,
    BS_SORT
  } back_state_t;

  // Sign-extend or truncate an input word to the storage width.
  function automatic word_t to_word(input logic signed [VALUE_W-1:0] v);
    return DATA_WIDTH'(v);
  endfunction

endpackage

// ----- sv/bale_front.sv -----
// Front end: accepts commands, decodes the action and hands them to the queue.
`timescale 1ns / 1ps

module bale_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [bale_pkg::ACTION_W-1:0] in_action,
  input  logic [bale_pkg::POS_W-1:0]    in_position,
  input  logic signed [bale_pkg::VALUE_W-1:0] in_value,
  output logic                          busy,
  input  logic                          q_ready,
  output logic                          q_push,
  output bale_pkg::cmd_t                q_cmd
);

  logic           valid_r;
  logic           valid_nxt;
  bale_pkg::cmd_t cmd_r;
  bale_pkg::cmd_t cmd_dec;
  logic           accept;

  assign busy   = valid_r && !q_ready;
  assign accept = start && !busy;
  assign q_push = valid_r && q_ready;
  assign q_cmd  = cmd_r;

  always_comb begin
    cmd_dec.position = in_position;
    cmd_dec.value    = bale_pkg::to_word(in_value);
    if (in_action > bale_pkg::ACT_LAST) begin
      cmd_dec.op = bale_pkg::OP_NONE;
    end else begin
      cmd_dec.op = bale_pkg::op_t'(in_action);
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (q_push) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= cmd_dec;
    end
  end

endmodule

// ----- sv/bale_queue.sv -----
// Short command queue between the front end and the back end.
`timescale 1ns / 1ps

module bale_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  bale_pkg::cmd_t push_cmd,
  output logic           ready,
  output logic           valid,
  input  logic           pop,
  output bale_pkg::cmd_t pop_cmd
);

  bale_pkg::cmd_t                 slot_r [bale_pkg::QDEPTH];
  logic [bale_pkg::QPTR_W-1:0]    wr_ptr_r;
  logic [bale_pkg::QPTR_W-1:0]    rd_ptr_r;
  logic [bale_pkg::QCNT_W-1:0]    cnt_r;
  logic [bale_pkg::QCNT_W-1:0]    cnt_nxt;
  logic                           do_push;
  logic                           do_pop;

  assign ready   = cnt_r < bale_pkg::QCNT_W'(bale_pkg::QDEPTH);
  assign valid   = cnt_r != '0;
  assign pop_cmd = slot_r[rd_ptr_r];
  assign do_push = push && ready;
  assign do_pop  = pop && valid;

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ----- sv/bale_back.sv -----
// Back end: holds the list registers and carries out one command at a time.
`timescale 1ns / 1ps

module bale_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_valid,
  input  bale_pkg::cmd_t               q_cmd,
  output logic                         q_pop,
  output logic                         out_strobe,
  output logic                         out_ok,
  output logic [bale_pkg::POS_W-1:0]   out_found_index,
  output logic signed [bale_pkg::VALUE_W-1:0] out_read_value,
  output logic [bale_pkg::LEN_W-1:0]   out_length
);

  localparam int CAP = bale_pkg::CAPACITY;

  bale_pkg::word_t elem_r   [CAP];
  bale_pkg::word_t elem_nxt [CAP];
  bale_pkg::word_t above    [CAP];
  bale_pkg::word_t below    [CAP];

  logic [bale_pkg::CNT_W-1:0] count_r;
  logic [bale_pkg::CNT_W-1:0] count_nxt;
  logic [bale_pkg::CNT_W-1:0] pass_r;
  logic [bale_pkg::CNT_W-1:0] pass_nxt;
  bale_pkg::back_state_t      state_r;
  bale_pkg::back_state_t      state_nxt;

  logic [CAP-1:0] live;
  logic [CAP-1:0] match;
  logic [CAP-1:0] not_gt;
  logic [CAP-1:0] swap_up;
  logic [CAP-1:0] swap_dn;

  logic [bale_pkg::IDX_W-1:0] first_idx;
  logic                       any_match;
  logic [bale_pkg::CNT_W-1:0] sort_slot;
  logic                       full;
  logic                       empty;
  logic [bale_pkg::CMP_W-1:0] pos_w;
  logic [bale_pkg::CMP_W-1:0] cnt_w;
  logic                       sort_last;

  logic                       ins_en;
  logic [bale_pkg::IDX_W-1:0] ins_at;
  logic                       del_en;
  logic [bale_pkg::IDX_W-1:0] del_at;
  logic                       sort_en;

  logic                       res_valid;
  logic                       res_ok;
  logic [bale_pkg::IDX_W-1:0] res_found;
  bale_pkg::word_t            res_rd;

  logic                       strobe_r;
  logic                       ok_r;
  logic [bale_pkg::POS_W-1:0] found_r;
  logic [bale_pkg::VALUE_W-1:0] rd_r;
  logic [bale_pkg::LEN_W-1:0] len_r;

  // Per-entry neighbors, compares and compare-exchange pairs.
  for (genvar g = 0; g < CAP; g++) begin : g_entry
    assign live[g]   = bale_pkg::CNT_W'(g) < count_r;
    assign match[g]  = live[g] && (elem_r[g] == q_cmd.value);
    assign not_gt[g] = live[g] && !($signed(q_cmd.value) < $signed(elem_r[g]));
    if (g == CAP - 1) begin : g_top
      assign above[g]   = elem_r[g];
      assign swap_up[g] = 1'b0;
    end else begin : g_mid
      assign above[g]   = elem_r[g+1];
      // Pairs start at even entries on even passes and at odd entries on odd passes.
      assign swap_up[g] = (pass_r[0] == 1'(g % 2)) &&
                          (bale_pkg::CNT_W'(g + 1) < count_r) &&
                          ($signed(elem_r[g+1]) < $signed(elem_r[g]));
    end
    if (g == 0) begin : g_bot
      assign below[g]   = elem_r[g];
      assign swap_dn[g] = 1'b0;
    end else begin : g_upper
      assign below[g]   = elem_r[g-1];
      assign swap_dn[g] = swap_up[g-1];
    end
  end

  always_comb begin
    first_idx = '0;
    for (int i = CAP - 1; i >= 0; i--) begin
      if (match[i]) begin
        first_idx = bale_pkg::IDX_W'(i);
      end
    end
  end

  // Sorted insert lands just above the last element that is not greater than value.
  always_comb begin
    sort_slot = '0;
    for (int i = 0; i < CAP; i++) begin
      if (not_gt[i]) begin
        sort_slot = bale_pkg::CNT_W'(i + 1);
      end
    end
  end

  assign any_match = |match;
  assign full      = count_r == bale_pkg::CNT_W'(CAP);
  assign empty     = count_r == '0;
  assign pos_w     = bale_pkg::CMP_W'(q_cmd.position);
  assign cnt_w     = bale_pkg::CMP_W'(count_r);
  assign sort_last = ((bale_pkg::CNT_W + 1)'(pass_r) + (bale_pkg::CNT_W + 1)'(1))
                     >= (bale_pkg::CNT_W + 1)'(count_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bale_pkg::BS_IDLE: begin
        if (q_valid && (q_cmd.op == bale_pkg::OP_SORT)) begin
          state_nxt = bale_pkg::BS_SORT;
        end
      end
      bale_pkg::BS_SORT: begin
        if (sort_last) begin
          state_nxt = bale_pkg::BS_IDLE;
        end
      end
      default: state_nxt = bale_pkg::BS_IDLE;
    endcase
  end

  always_comb begin
    q_pop     = 1'b0;
    ins_en    = 1'b0;
    ins_at    = '0;
    del_en    = 1'b0;
    del_at    = '0;
    sort_en   = 1'b0;
    count_nxt = count_r;
    pass_nxt  = '0;
    res_valid = 1'b0;
    res_ok    = 1'b0;
    res_found = '0;
    res_rd    = '0;
    unique case (state_r)
      bale_pkg::BS_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          res_valid = q_cmd.op != bale_pkg::OP_SORT;
          unique case (q_cmd.op)
            bale_pkg::OP_PUSH_BACK: begin
              if (!full) begin
                ins_en = 1'b1;
                ins_at = count_r[bale_pkg::IDX_W-1:0];
                res_ok = 1'b1;
              end
            end
            bale_pkg::OP_PUSH_FRONT: begin
              if (!full) begin
                ins_en = 1'b1;
                res_ok = 1'b1;
              end
            end
            bale_pkg::OP_POP_BACK: begin
              if (!empty) begin
                count_nxt = count_r - 1'b1;
                res_ok    = 1'b1;
              end
            end
            bale_pkg::OP_POP_FRONT: begin
              if (!empty) begin
                del_en = 1'b1;
                res_ok = 1'b1;
              end
            end
            bale_pkg::OP_INSERT_AT: begin
              if (!full && (pos_w <= cnt_w)) begin
                ins_en = 1'b1;
                ins_at = bale_pkg::IDX_W'(q_cmd.position);
                res_ok = 1'b1;
              end
            end
            bale_pkg::OP_INSERT_SORTED: begin
              if (!full) begin
                ins_en = 1'b1;
                ins_at = bale_pkg::IDX_W'(sort_slot);
                res_ok = 1'b1;
              end
            end
            bale_pkg::OP_ERASE_AT: begin
              if (pos_w < cnt_w) begin
                del_en = 1'b1;
                del_at = bale_pkg::IDX_W'(q_cmd.position);
                res_ok = 1'b1;
              end
            end
            bale_pkg::OP_ERASE_VALUE: begin
              if (any_match) begin
                del_en = 1'b1;
                del_at = first_idx;
                res_ok = 1'b1;
              end
            end
            bale_pkg::OP_FIND: begin
              if (any_match) begin
                res_found = first_idx;
                res_ok    = 1'b1;
              end
            end
            bale_pkg::OP_SORT: begin
              res_ok = 1'b1;
            end
            bale_pkg::OP_CLEAR: begin
              count_nxt = '0;
              res_ok    = 1'b1;
            end
            bale_pkg::OP_READ_AT: begin
              if (pos_w < cnt_w) begin
                res_rd = elem_r[bale_pkg::IDX_W'(q_cmd.position)];
                res_ok = 1'b1;
              end
            end
            bale_pkg::OP_NONE: begin
              res_ok = 1'b0;
            end
            default: begin
              res_ok = 1'b0;
            end
          endcase
          if (ins_en) begin
            count_nxt = count_r + 1'b1;
          end else if (del_en) begin
            count_nxt = count_r - 1'b1;
          end
        end
      end
      bale_pkg::BS_SORT: begin
        sort_en   = 1'b1;
        pass_nxt  = pass_r + 1'b1;
        res_valid = sort_last;
        res_ok    = 1'b1;
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  always_comb begin
    for (int i = 0; i < CAP; i++) begin
      elem_nxt[i] = elem_r[i];
      if (ins_en) begin
        if (bale_pkg::IDX_W'(i) == ins_at) begin
          elem_nxt[i] = q_cmd.value;
        end else if (bale_pkg::IDX_W'(i) > ins_at) begin
          elem_nxt[i] = below[i];
        end
      end
      if (del_en && (bale_pkg::IDX_W'(i) >= del_at)) begin
        elem_nxt[i] = above[i];
      end
      if (sort_en) begin
        if (swap_up[i]) begin
          elem_nxt[i] = above[i];
        end else if (swap_dn[i]) begin
          elem_nxt[i] = below[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= bale_pkg::BS_IDLE;
      count_r  <= '0;
      pass_r   <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      pass_r   <= pass_nxt;
      strobe_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < CAP; i++) begin
      elem_r[i] <= elem_nxt[i];
    end
    ok_r    <= res_ok;
    found_r <= bale_pkg::POS_W'(res_found);
    rd_r    <= bale_pkg::VALUE_W'(res_rd);
    len_r   <= bale_pkg::LEN_W'(count_nxt);
  end

  assign out_strobe      = strobe_r;
  assign out_ok          = ok_r;
  assign out_found_index = found_r;
  assign out_read_value  = $signed(rd_r);
  assign out_length      = len_r;

endmodule

// ----- sv/bounded_array_list_engine_unit.sv -----
// Top level of the bounded array list engine: front end, command queue and back end.
//
// Usage: drive in_action, in_position and in_value with start high; the command is
// transferred at a rising edge where start is high and busy is low. Every command
// gives exactly one result: out_strobe is high for one cycle with out_ok,
// out_found_index, out_read_value and out_length, and that transfer cannot be
// held off by the receiver.
// Every command passes through the front register and a queue slot, then the back
// end carries it out and registers its result. Sort runs one odd-even
// compare-exchange pass per cycle over the back end list registers, max(1, length)
// passes, and its result is registered with the last pass.
// Throughput: one command per cycle while no sort runs; during a sort the
// two-entry queue and the front register fill, then busy rises until the sort
// ends. Rate is set by the back end, which retires one command per cycle when not sorting.
// Reset (rst_n low, synchronous) empties the list and the queue and drops any
// pending result; element storage keeps no reset value and is only read below
// the current length.
`timescale 1ns / 1ps

module bounded_array_list_engine_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [bale_pkg::ACTION_W-1:0]       in_action,
  input  logic [bale_pkg::POS_W-1:0]          in_position,
  input  logic signed [bale_pkg::VALUE_W-1:0] in_value,
  output logic                                out_strobe,
  output logic                                out_ok,
  output logic [bale_pkg::POS_W-1:0]          out_found_index,
  output logic signed [bale_pkg::VALUE_W-1:0] out_read_value,
  output logic [bale_pkg::LEN_W-1:0]          out_length
);

  logic           q_ready;
  logic           q_push;
  bale_pkg::cmd_t fe_cmd;
  logic           q_valid;
  logic           q_pop;
  bale_pkg::cmd_t be_cmd;

  bale_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .in_action   (in_action),
    .in_position (in_position),
    .in_value    (in_value),
    .busy        (busy),
    .q_ready     (q_ready),
    .q_push      (q_push),
    .q_cmd       (fe_cmd)
  );

  bale_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (fe_cmd),
    .ready    (q_ready),
    .valid    (q_valid),
    .pop      (q_pop),
    .pop_cmd  (be_cmd)
  );

  bale_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_cmd           (be_cmd),
    .q_pop           (q_pop),
    .out_strobe      (out_strobe),
    .out_ok          (out_ok),
    .out_found_index (out_found_index),
    .out_read_value  (out_read_value),
    .out_length      (out_length)
  );

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_length <= bale_pkg::LEN_W'(bale_pkg::CAPACITY)))
    else $error("result length exceeds capacity");

  a_read_needs_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_read_value != '0)) |-> out_ok)
    else $error("nonzero read value on a rejected command");

  a_found_needs_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_found_index != '0)) |-> out_ok)
    else $error("nonzero found index on a rejected command");

  a_busy_after_reset: assert property (@(posedge clk)
    !rst_n |=> !busy)
    else $error("busy right after reset");

endmodule

// ----- tb/sv/bounded_array_list_engine_unit_test.sv -----
// Self-checking testbench of the bounded array list engine with a shadow list predictor.
`timescale 1ns / 1ps

module bounded_array_list_engine_unit_test;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 20;
  localparam int SCRIPT_ROWS = 27;
  localparam int ITEMS_PER_PHASE = 335;
  localparam int PHASES = 4;
  localparam logic [bale_pkg::ACTION_W-1:0] ACT_SPARE_FIRST = bale_pkg::OP_NONE;
  localparam logic [bale_pkg::ACTION_W-1:0] ACT_SPARE_LAST = 4'hF;

  typedef struct packed {
    logic                         ok;
    logic [bale_pkg::POS_W-1:0]   found_index;
    logic [bale_pkg::VALUE_W-1:0] read_value;
    logic [bale_pkg::LEN_W-1:0]   len_after;
  } list_result_t;

  typedef struct {
    logic [bale_pkg::ACTION_W-1:0] action;
    logic [bale_pkg::POS_W-1:0]    position;
    logic [bale_pkg::VALUE_W-1:0]  value;
    bit                            typed;
    logic                          want_ok;
    logic [bale_pkg::LEN_W-1:0]    want_len;
  } script_row_t;

  logic clk;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [bale_pkg::ACTION_W-1:0] in_action = '0;
  logic [bale_pkg::POS_W-1:0] in_position = '0;
  logic signed [bale_pkg::VALUE_W-1:0] in_value = '0;
  logic out_strobe;
  logic out_ok;
  logic [bale_pkg::POS_W-1:0] out_found_index;
  logic signed [bale_pkg::VALUE_W-1:0] out_read_value;
  logic [bale_pkg::LEN_W-1:0] out_length;

  // Shadow copy of the list contents, updated at each accepted command transfer.
  bale_pkg::word_t shadow_words [bale_pkg::CAPACITY];
  int shadow_len = 0;

  list_result_t pending_results [$];
  script_row_t cmd_script [SCRIPT_ROWS];
  int idle_pct = 0;
  int mismatch_count = 0;
  int items_sent = 0;
  int results_checked = 0;
  int rejects_seen = 0;
  int cycle_count = 0;

  bounded_array_list_engine_unit dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_action(in_action),
    .in_position(in_position),
    .in_value(in_value),
    .out_strobe(out_strobe),
    .out_ok(out_ok),
    .out_found_index(out_found_index),
    .out_read_value(out_read_value),
    .out_length(out_length)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void shift_up_at(int at, bale_pkg::word_t v);
    for (int i = shadow_len; i > at; i--) begin
      shadow_words[i] = shadow_words[i-1];
    end
    shadow_words[at] = v;
    shadow_len++;
  endfunction

  function automatic void remove_at(int at);
    for (int i = at; i + 1 < shadow_len; i++) begin
      shadow_words[i] = shadow_words[i+1];
    end
    shadow_len--;
  endfunction

  // Applies one command to the shadow list and returns the result it should produce.
  function automatic list_result_t predict_list_step(logic [bale_pkg::ACTION_W-1:0] action,
                                                     logic [bale_pkg::POS_W-1:0] pos,
                                                     logic [bale_pkg::VALUE_W-1:0] value);
    list_result_t r;
    bale_pkg::word_t v;
    bale_pkg::word_t tmp;
    int i;
    bit full;
    bit empty;
    r = '0;
    v = bale_pkg::word_t'($signed(value));
    full = shadow_len >= bale_pkg::CAPACITY;
    empty = shadow_len == 0;
    case (action)
      bale_pkg::OP_PUSH_BACK: begin
        if (!full) begin
          shadow_words[shadow_len] = v;
          shadow_len++;
          r.ok = 1'b1;
        end
      end
      bale_pkg::OP_PUSH_FRONT: begin
        if (!full) begin
          shift_up_at(0, v);
          r.ok = 1'b1;
        end
      end
      bale_pkg::OP_POP_BACK: begin
        if (!empty) begin
          shadow_len--;
          r.ok = 1'b1;
        end
      end
      bale_pkg::OP_POP_FRONT: begin
        if (!empty) begin
          remove_at(0);
          r.ok = 1'b1;
        end
      end
      bale_pkg::OP_INSERT_AT: begin
        if (!full && pos <= shadow_len) begin
          shift_up_at(int'(pos), v);
          r.ok = 1'b1;
        end
      end
      bale_pkg::OP_INSERT_SORTED: begin
        if (!full) begin
          // Walk down from the end, moving every larger element up one place.
          i = shadow_len;
          while (i > 0 && $signed(v) < $signed(shadow_words[i-1])) begin
            shadow_words[i] = shadow_words[i-1];
            i--;
          end
          shadow_words[i] = v;
          shadow_len++;
          r.ok = 1'b1;
        end
      end
      bale_pkg::OP_ERASE_AT: begin
        if (pos < shadow_len) begin
          remove_at(int'(pos));
          r.ok = 1'b1;
        end
      end
      bale_pkg::OP_ERASE_VALUE: begin
        for (i = 0; i < shadow_len; i++) begin
          if (shadow_words[i] == v) begin
            remove_at(i);
            r.ok = 1'b1;
            break;
          end
        end
      end
      bale_pkg::OP_FIND: begin
        for (i = 0; i < shadow_len; i++) begin
          if (shadow_words[i] == v) begin
            r.ok = 1'b1;
            r.found_index = bale_pkg::POS_W'(i);
            break;
          end
        end
      end
      bale_pkg::OP_SORT: begin
        for (i = 0; i < shadow_len; i++) begin
          for (int j = i + 1; j < shadow_len; j++) begin
            if ($signed(shadow_words[j]) < $signed(shadow_words[i])) begin
              tmp = shadow_words[i];
              shadow_words[i] = shadow_words[j];
              shadow_words[j] = tmp;
            end
          end
        end
        r.ok = 1'b1;
      end
      bale_pkg::OP_CLEAR: begin
        shadow_len = 0;
        r.ok = 1'b1;
      end
      bale_pkg::OP_READ_AT: begin
        if (pos < shadow_len) begin
          r.read_value = bale_pkg::VALUE_W'(shadow_words[pos]);
          r.ok = 1'b1;
        end
      end
      default: ;
    endcase
    r.len_after = bale_pkg::LEN_W'(shadow_len);
    return r;
  endfunction

  // Waits out the sender's idle cycles, then holds the command until its transfer.
  task automatic transfer_cmd(input logic [bale_pkg::ACTION_W-1:0] action,
                              input logic [bale_pkg::POS_W-1:0] pos,
                              input logic [bale_pkg::VALUE_W-1:0] value, input bit typed,
                              input logic want_ok,
                              input logic [bale_pkg::LEN_W-1:0] want_len);
    list_result_t predicted;
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_action <= action;
    in_position <= pos;
    in_value <= value;
    do @(posedge clk); while (busy !== 1'b0);
    predicted = predict_list_step(action, pos, value);
    if (typed) begin
      pending_results.insert(pending_results.size(), '{want_ok, '0, '0, want_len});
    end else begin
      pending_results.insert(pending_results.size(), predicted);
    end
    items_sent++;
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk) begin
    list_result_t want;
    if (rst_n === 1'b1 && out_strobe !== 1'b0) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result transfer: ok=%0b length=%0d", out_ok, out_length);
        mismatch_count++;
      end else begin
        want = pending_results[0];
        pending_results.delete(0);
        results_checked++;
        if (out_ok === 1'b0) rejects_seen++;
        if (out_ok !== want.ok) begin
          $error("ok: expected %0b, got %0b", want.ok, out_ok);
          mismatch_count++;
        end
        if (out_found_index !== want.found_index) begin
          $error("found_index: expected %0d, got %0d", want.found_index, out_found_index);
          mismatch_count++;
        end
        if (out_read_value !== want.read_value) begin
          $error("read_value: expected %0d, got %0d", $signed(want.read_value),
                 out_read_value);
          mismatch_count++;
        end
        if (out_length !== want.len_after) begin
          $error("length: expected %0d, got %0d", want.len_after, out_length);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    int phase;
    int n;
    int r;
    bit shrinking;
    logic [bale_pkg::ACTION_W-1:0] act;
    logic [bale_pkg::POS_W-1:0] pos;
    logic [bale_pkg::VALUE_W-1:0] val;
    int phase_idle [PHASES];

    phase_idle = '{0, 80, 30, 0};
    shrinking = 1'b0;
    // Typed rows cover empty and full rejections, bad positions, extremes and clear.
    cmd_script = '{
      '{bale_pkg::OP_POP_BACK,      4'd0,  32'd0,         1'b1, 1'b0, 4'd0},
      '{bale_pkg::OP_POP_FRONT,     4'd0,  32'd0,         1'b1, 1'b0, 4'd0},
      '{bale_pkg::OP_ERASE_AT,      4'd0,  32'd0,         1'b1, 1'b0, 4'd0},
      '{bale_pkg::OP_READ_AT,       4'd0,  32'd0,         1'b1, 1'b0, 4'd0},
      '{bale_pkg::OP_FIND,          4'd0,  32'd5,         1'b1, 1'b0, 4'd0},
      '{bale_pkg::OP_ERASE_VALUE,   4'd0,  32'd5,         1'b1, 1'b0, 4'd0},
      '{bale_pkg::OP_PUSH_BACK,     4'd0,  32'h7FFF_FFFF, 1'b1, 1'b1, 4'd1},
      '{bale_pkg::OP_PUSH_FRONT,    4'd0,  32'h8000_0000, 1'b1, 1'b1, 4'd2},
      '{bale_pkg::OP_INSERT_AT,     4'd3,  32'd1,         1'b1, 1'b0, 4'd2},
      '{bale_pkg::OP_INSERT_AT,     4'd2,  32'd0,         1'b1, 1'b1, 4'd3},
      '{bale_pkg::OP_INSERT_SORTED, 4'd0,  32'hFFFF_FFFF, 1'b0, 1'b0, 4'd0},
      '{bale_pkg::OP_READ_AT,       4'd1,  32'd0,         1'b0, 1'b0, 4'd0},
      '{ACT_SPARE_FIRST,            4'd0,  32'd0,         1'b0, 1'b0, 4'd0},
      '{ACT_SPARE_LAST,             4'd15, 32'hFFFF_FFFF, 1'b0, 1'b0, 4'd0},
      '{bale_pkg::OP_READ_AT,       4'd15, 32'd0,         1'b1, 1'b0, 4'd4},
      '{bale_pkg::OP_PUSH_BACK,     4'd0,  32'd3,         1'b0, 1'b0, 4'd0},
      '{bale_pkg::OP_PUSH_FRONT,    4'd0,  32'd2,         1'b0, 1'b0, 4'd0},
      '{bale_pkg::OP_INSERT_SORTED, 4'd0,  32'd1,         1'b0, 1'b0, 4'd0},
      '{bale_pkg::OP_INSERT_AT,     4'd7,  32'hFFFF_FFFB, 1'b0, 1'b0, 4'd0},
      '{bale_pkg::OP_PUSH_BACK,     4'd0,  32'd9,         1'b1, 1'b0, 4'd8},
      '{bale_pkg::OP_INSERT_SORTED, 4'd0,  32'd4,         1'b1, 1'b0, 4'd8},
      '{bale_pkg::OP_SORT,          4'd0,  32'd0,         1'b0, 1'b0, 4'd0},
      '{bale_pkg::OP_FIND,          4'd0,  32'd1,         1'b0, 1'b0, 4'd0},
      '{bale_pkg::OP_ERASE_VALUE,   4'd0,  32'h7FFF_FFFF, 1'b0, 1'b0, 4'd0},
      '{bale_pkg::OP_ERASE_AT,      4'd7,  32'd0,         1'b1, 1'b0, 4'd7},
      '{bale_pkg::OP_ERASE_AT,      4'd6,  32'd0,         1'b0, 1'b0, 4'd0},
      '{bale_pkg::OP_CLEAR,         4'd0,  32'd0,         1'b1, 1'b1, 4'd0}
    };

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    for (n = 0; n < SCRIPT_ROWS; n++) begin
      transfer_cmd(cmd_script[n].action, cmd_script[n].position, cmd_script[n].value,
                   cmd_script[n].typed, cmd_script[n].want_ok, cmd_script[n].want_len);
    end

    for (phase = 0; phase < PHASES; phase++) begin
      idle_pct = phase_idle[phase];
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        // Swing between filling and draining so both full and empty lists come up often.
        if (shadow_len == bale_pkg::CAPACITY) shrinking = 1'b1;
        else if (shadow_len == 0) shrinking = 1'b0;
        else if ($urandom_range(39) == 0) shrinking = !shrinking;

        r = $urandom_range(99);
        if (r < 3) begin
          act = bale_pkg::ACTION_W'($urandom_range(int'(ACT_SPARE_FIRST),
                                                   int'(ACT_SPARE_LAST)));
        end else if (r < 4) begin
          act = bale_pkg::OP_CLEAR;
        end else if (r < (shrinking ? 30 : 60)) begin
          case ($urandom_range(3))
            0: act = bale_pkg::OP_PUSH_BACK;
            1: act = bale_pkg::OP_PUSH_FRONT;
            2: act = bale_pkg::OP_INSERT_AT;
            default: act = bale_pkg::OP_INSERT_SORTED;
          endcase
        end else if (r < 85) begin
          case ($urandom_range(3))
            0: act = bale_pkg::OP_POP_BACK;
            1: act = bale_pkg::OP_POP_FRONT;
            2: act = bale_pkg::OP_ERASE_AT;
            default: act = bale_pkg::OP_ERASE_VALUE;
          endcase
        end else begin
          case ($urandom_range(2))
            0: act = bale_pkg::OP_FIND;
            1: act = bale_pkg::OP_SORT;
            default: act = bale_pkg::OP_READ_AT;
          endcase
        end

        if ($urandom_range(4) == 0) pos = bale_pkg::POS_W'($urandom_range(15));
        else pos = bale_pkg::POS_W'($urandom_range(shadow_len));

        r = $urandom_range(9);
        if (r < 4 && shadow_len > 0) begin
          val = bale_pkg::VALUE_W'(shadow_words[$urandom_range(shadow_len - 1)]);
        end else if (r < 6) begin
          val = bale_pkg::VALUE_W'($signed($urandom_range(16)) - 8);
        end else if (r < 7) begin
          case ($urandom_range(3))
            0: val = 32'h8000_0000;
            1: val = 32'h7FFF_FFFF;
            2: val = 32'hFFFF_FFFF;
            default: val = 32'h0000_0000;
          endcase
        end else begin
          val = $urandom();
        end

        transfer_cmd(act, pos, val, 1'b0, 1'b0, '0);
      end
    end

    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d list commands over back-to-back, 80%% idle and 30%% idle pacing;",
             items_sent);
    $display("compared %0d results, %0d of them rejections.", results_checked, rejects_seen);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
